>>> hdl/bdda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_pkg
// Shared types, constants and calendar helpers for the business-day adder.
// ----------------------------------------------------------------------------
package bdda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 12;
  localparam int WDAY_W  = 3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // shared constant divider
  localparam int DIV_W   = 15;
  localparam int DSOR_W  = 8;

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
  localparam logic [MONTH_W-1:0] JANUARY   = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
  localparam logic [MONTH_W-1:0] MARCH     = 4'd3;
  localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
  localparam logic [WDAY_W-1:0]  SUNDAY    = 3'd0;
  localparam logic [WDAY_W-1:0]  SATURDAY  = 3'd6;
  localparam logic [6:0]         LAST_YEAR_OF_CENTURY = 7'd99;

  localparam logic [DSOR_W-1:0] CENTURY = 8'd100;
  localparam logic [DSOR_W-1:0] WEEK    = 8'd7;

  typedef enum logic {
    DIV_BY_CENTURY,
    DIV_BY_WEEK
  } div_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_YEAR,
    S_WAIT_YEAR,
    S_CHECK,
    S_WAIT_WEEK,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;       // capture input item
    logic     div_start;
    div_sel_t div_sel;
    logic     check;      // latch validity and leap counters
    logic     walk_init;  // take start weekday from divider
    logic     step;       // advance one calendar day
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic bad;
    logic weekend;
    logic count_zero;
  } stat_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 with mm the March-based month number
  function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] t;
    case (m)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/bdda_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_div
// Divider by 100 or by 7 through reciprocal multiplication and back-subtraction.
// ----------------------------------------------------------------------------
module bdda_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  bdda_pkg::div_sel_t           sel,
  input  logic [bdda_pkg::DIV_W-1:0]   dividend,
  output logic [bdda_pkg::DIV_W-1:0]   quotient,
  output logic [bdda_pkg::DSOR_W-1:0]  remainder,
  output logic                         done
);

  localparam int PROD_W = 2 * bdda_pkg::DIV_W;
  // ceil(2^19 / 100) and ceil(2^17 / 7), exact for every 15-bit dividend
  localparam logic [bdda_pkg::DIV_W-1:0] RECIP_CENTURY = 15'd5243;
  localparam logic [bdda_pkg::DIV_W-1:0] RECIP_WEEK    = 15'd18725;
  localparam int SHIFT_CENTURY = 19;
  localparam int SHIFT_WEEK    = 17;

  logic                          mul_r, mul_nxt;
  logic                          sub_r, sub_nxt;
  logic                          done_r, done_nxt;
  bdda_pkg::div_sel_t            sel_r, sel_nxt;
  logic [bdda_pkg::DIV_W-1:0]    num_r, num_nxt;
  logic [bdda_pkg::DIV_W-1:0]    quo_r, quo_nxt;
  logic [bdda_pkg::DSOR_W-1:0]   rem_r, rem_nxt;
  logic [bdda_pkg::DIV_W-1:0]    recip;
  logic [bdda_pkg::DIV_W-1:0]    dsor;
  logic [PROD_W-1:0]             prod;
  logic [bdda_pkg::DIV_W-1:0]    quo_est;
  logic [bdda_pkg::DIV_W-1:0]    back;
  logic [bdda_pkg::DIV_W-1:0]    diff;

  assign recip = (sel_r == bdda_pkg::DIV_BY_WEEK) ? RECIP_WEEK : RECIP_CENTURY;
  assign dsor  = (sel_r == bdda_pkg::DIV_BY_WEEK) ? bdda_pkg::DIV_W'(bdda_pkg::WEEK)
                                                  : bdda_pkg::DIV_W'(bdda_pkg::CENTURY);
  assign prod    = PROD_W'(num_r) * PROD_W'(recip);
  assign quo_est = (sel_r == bdda_pkg::DIV_BY_WEEK) ? bdda_pkg::DIV_W'(prod >> SHIFT_WEEK)
                                                    : bdda_pkg::DIV_W'(prod >> SHIFT_CENTURY);
  assign back    = quo_r * dsor;
  assign diff    = num_r - back;

  always_comb begin
    mul_nxt  = start;
    sub_nxt  = mul_r;
    done_nxt = sub_r;
    sel_nxt  = sel_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      sel_nxt = sel;
      num_nxt = dividend;
    end
    if (mul_r) begin
      quo_nxt = quo_est;
    end
    if (sub_r) begin
      rem_nxt = diff[bdda_pkg::DSOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      sub_r  <= sub_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

>>> hdl/bdda_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_datapath
// Date registers, leap-year counters, weekday tracking and result register.
// ----------------------------------------------------------------------------
module bdda_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bdda_pkg::cmd_t                   cmd,
  output bdda_pkg::stat_t                  stat,
  input  logic [bdda_pkg::IN_DATA_W-1:0]   in_data,
  output logic [bdda_pkg::OUT_DATA_W-1:0]  out_data,
  output logic                             out_bad
);

  logic [bdda_pkg::YEAR_W-1:0]   y_r, y_nxt;
  logic [bdda_pkg::MONTH_W-1:0]  m_r, m_nxt;
  logic [bdda_pkg::DAY_W-1:0]    d_r, d_nxt;
  logic [bdda_pkg::COUNT_W-1:0]  n_r, n_nxt;
  logic [bdda_pkg::WDAY_W-1:0]   w_r, w_nxt;
  logic [1:0]                    c4_r, c4_nxt;    // year mod 4
  logic [6:0]                    c100_r, c100_nxt; // year mod 100
  logic [1:0]                    cq_r, cq_nxt;    // (year / 100) mod 4
  logic                          bad_r, bad_nxt;
  logic [bdda_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                          out_bad_r, out_bad_nxt;

  logic [bdda_pkg::DIV_W-1:0]    dividend;
  logic [bdda_pkg::DIV_W-1:0]    quo;
  logic [bdda_pkg::DSOR_W-1:0]   rem;
  logic                          div_done;

  logic                          leap_chk, leap_walk, bad_chk, weekend;
  logic                          jan_feb;
  logic [bdda_pkg::YEAR_W-1:0]   yy;
  logic [7:0]                    yyq;
  logic [bdda_pkg::DIV_W-1:0]    wsum;
  logic [bdda_pkg::DAY_W-1:0]    mlen;
  logic [bdda_pkg::WDAY_W-1:0]   w_out;

  bdda_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .sel       (cmd.div_sel),
    .dividend  (dividend),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  // leap test of the start year from y / 100 and y mod 100
  assign leap_chk = (y_r[1:0] == 2'd0) && ((rem != '0) || (quo[1:0] == 2'd0));
  assign bad_chk  = (y_r == '0) || (y_r > bdda_pkg::MAX_YEAR) ||
                    (m_r == '0) || (m_r > bdda_pkg::DECEMBER) ||
                    (d_r == '0) || (d_r > bdda_pkg::month_len(m_r, leap_chk));

  // Sakamoto sum: January and February count in the previous year
  assign jan_feb = (m_r < bdda_pkg::MARCH);
  assign yy      = y_r - bdda_pkg::YEAR_W'(jan_feb);
  assign yyq     = (jan_feb && (rem == '0)) ? (quo[7:0] - 8'd1) : quo[7:0];
  assign wsum    = bdda_pkg::DIV_W'(d_r) + bdda_pkg::DIV_W'(yy) +
                   bdda_pkg::DIV_W'(yy >> 2) - bdda_pkg::DIV_W'(yyq) +
                   bdda_pkg::DIV_W'(yyq >> 2) +
                   bdda_pkg::DIV_W'(bdda_pkg::month_offset(m_r));

  assign dividend = (cmd.div_sel == bdda_pkg::DIV_BY_WEEK) ? wsum
                                                           : bdda_pkg::DIV_W'(y_r);

  assign leap_walk = (c4_r == 2'd0) && ((c100_r != 7'd0) || (cq_r == 2'd0));
  assign mlen      = bdda_pkg::month_len(m_r, leap_walk);
  assign weekend   = (w_r == bdda_pkg::SUNDAY) || (w_r == bdda_pkg::SATURDAY);
  assign w_out     = bad_r ? bdda_pkg::SUNDAY : w_r;

  always_comb begin
    y_nxt        = y_r;
    m_nxt        = m_r;
    d_nxt        = d_r;
    n_nxt        = n_r;
    w_nxt        = w_r;
    c4_nxt       = c4_r;
    c100_nxt     = c100_r;
    cq_nxt       = cq_r;
    bad_nxt      = bad_r;
    out_data_nxt = out_data_r;
    out_bad_nxt  = out_bad_r;

    if (cmd.load) begin
      y_nxt = in_data[13:0];
      m_nxt = in_data[17:14];
      d_nxt = in_data[22:18];
      n_nxt = in_data[34:23];
    end

    if (cmd.check) begin
      bad_nxt  = bad_chk;
      c4_nxt   = y_r[1:0];
      c100_nxt = rem[6:0];
      cq_nxt   = quo[1:0];
    end

    if (cmd.walk_init) begin
      w_nxt = rem[bdda_pkg::WDAY_W-1:0];
    end

    if (cmd.step) begin
      if (!weekend) begin
        n_nxt = n_r - 1'b1;
      end
      w_nxt = (w_r == bdda_pkg::SATURDAY) ? bdda_pkg::SUNDAY : (w_r + 1'b1);
      if (d_r >= mlen) begin
        d_nxt = bdda_pkg::FIRST_DAY;
        if (m_r >= bdda_pkg::DECEMBER) begin
          m_nxt  = bdda_pkg::JANUARY;
          y_nxt  = y_r + 1'b1;
          c4_nxt = c4_r + 1'b1;
          if (c100_r == bdda_pkg::LAST_YEAR_OF_CENTURY) begin
            c100_nxt = 7'd0;
            cq_nxt   = cq_r + 1'b1;
          end else begin
            c100_nxt = c100_r + 1'b1;
          end
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end else begin
        d_nxt = d_r + 1'b1;
      end
    end

    if (cmd.out_load) begin
      out_data_nxt = {6'd0, w_out, d_r, m_r, y_r};
      out_bad_nxt  = bad_r;
    end
  end

  always_ff @(posedge clk) begin
    y_r        <= y_nxt;
    m_r        <= m_nxt;
    d_r        <= d_nxt;
    n_r        <= n_nxt;
    w_r        <= w_nxt;
    c4_r       <= c4_nxt;
    c100_r     <= c100_nxt;
    cq_r       <= cq_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign stat.div_done   = div_done;
  assign stat.bad        = bad_chk;
  assign stat.weekend    = weekend;
  assign stat.count_zero = (n_r == '0);

  assign out_data = out_data_r;
  assign out_bad  = out_bad_r;

endmodule

>>> hdl/bdda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_ctrl
// Sequencer: setup divisions, day-stepping walk and result handoff.
// ----------------------------------------------------------------------------
module bdda_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output bdda_pkg::cmd_t   cmd,
  input  bdda_pkg::stat_t  stat
);

  bdda_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdda_pkg::S_IDLE:      if (in_tvalid) state_nxt = bdda_pkg::S_DIV_YEAR;
      bdda_pkg::S_DIV_YEAR:  state_nxt = bdda_pkg::S_WAIT_YEAR;
      bdda_pkg::S_WAIT_YEAR: if (stat.div_done) state_nxt = bdda_pkg::S_CHECK;
      bdda_pkg::S_CHECK:     state_nxt = stat.bad ? bdda_pkg::S_DONE : bdda_pkg::S_WAIT_WEEK;
      bdda_pkg::S_WAIT_WEEK: if (stat.div_done) state_nxt = bdda_pkg::S_WALK;
      bdda_pkg::S_WALK:      if (!stat.weekend && stat.count_zero) state_nxt = bdda_pkg::S_DONE;
      bdda_pkg::S_DONE:      if (slot_free) state_nxt = bdda_pkg::S_IDLE;
      default:               state_nxt = bdda_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = bdda_pkg::DIV_BY_CENTURY;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      bdda_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      bdda_pkg::S_DIV_YEAR: begin
        cmd.div_start = 1'b1;
      end
      bdda_pkg::S_CHECK: begin
        cmd.check     = 1'b1;
        cmd.div_sel   = bdda_pkg::DIV_BY_WEEK;
        cmd.div_start = !stat.bad;
      end
      bdda_pkg::S_WAIT_WEEK: begin
        cmd.walk_init = stat.div_done;
      end
      bdda_pkg::S_WALK: begin
        cmd.step = stat.weekend || !stat.count_zero;
      end
      bdda_pkg::S_DONE: begin
        cmd.out_load = slot_free;
        if (slot_free) out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdda_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hdl/business_day_date_adder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// business_day_date_adder_unit
// Adds a count of business days to a Gregorian start date.
// ----------------------------------------------------------------------------
// One item at a time. After a transfer in, the unit first runs setup as two
// passes through a shared reciprocal-multiply divider (year by 100 for the
// leap rules, then the weekday sum by 7), then steps one calendar day per
// cycle, then sees the walk end and loads the result register, which raises
// out_tvalid. An invalid start date skips the walk and returns with bad_start
// set (out_tuser) and the start date echoed. A new input is taken while the
// previous result still waits for its transfer out.
module business_day_date_adder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] start_year, [17:14] start_month, [22:18] start_day,
  // [34:23] business_days, [39:35] zero
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [13:0] return_year, [17:14] return_month, [22:18] return_day,
  // [25:23] return_weekday, [31:26] zero
  output logic [31:0] out_tdata,
  // [0] bad_start
  output logic        out_tuser
);

  bdda_pkg::cmd_t  cmd;
  bdda_pkg::stat_t stat;

  bdda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  bdda_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_tdata),
    .out_data (out_tdata),
    .out_bad  (out_tuser)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the business-day date adder. A driver streams start
// dates and day counts in random bursts. Each accepted transfer is run through
// a day-by-day calendar walk here to get the expected return date. A monitor
// stalls the result side on its own pattern and compares every field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT   = 40000;
  localparam int SETTLE_TICKS = 100;
  localparam int RANDOM_TRIPS = 80;

  typedef struct packed {
    logic [bdda_pkg::COUNT_W-1:0] count;
    logic [bdda_pkg::DAY_W-1:0]   day;
    logic [bdda_pkg::MONTH_W-1:0] month;
    logic [bdda_pkg::YEAR_W-1:0]  year;
  } trip_t;

  typedef struct packed {
    logic                         bad;
    logic [bdda_pkg::WDAY_W-1:0]  weekday;
    logic [bdda_pkg::DAY_W-1:0]   day;
    logic [bdda_pkg::MONTH_W-1:0] month;
    logic [bdda_pkg::YEAR_W-1:0]  year;
  } return_date_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC
  } stall_mode_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [bdda_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [bdda_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  trip_t        trips_pending[$];
  return_date_t due_returns[$];
  trip_t        trip_on_bus;
  int unsigned  burst_left  = 1;
  int unsigned  gap_left    = 0;
  stall_mode_t  stall_mode  = READY_ALWAYS;
  int unsigned  mode_left   = 0;
  int unsigned  stall_phase = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  mismatch_count = 0;

  business_day_date_adder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- calendar predictor ----------------
  function automatic bit leap(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned days_in(int unsigned m, int unsigned y);
    if (m == bdda_pkg::FEBRUARY) return leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // Sakamoto-style, Sunday = 0; Jan/Feb count as months 11/12 of prior year
  function automatic int unsigned day_of_week(int unsigned y, int unsigned m,
                                              int unsigned d);
    int unsigned a, yy, mm;
    a  = (14 - m) / 12;
    yy = y - a;
    mm = m + 12 * a - 2;
    return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
  endfunction

  function automatic bit off_day(int unsigned y, int unsigned m, int unsigned d);
    int unsigned w;
    w = day_of_week(y, m, d);
    return w == bdda_pkg::SUNDAY || w == bdda_pkg::SATURDAY;
  endfunction

  function automatic void advance_day(inout int unsigned y, inout int unsigned m,
                                      inout int unsigned d);
    if (d >= days_in(m, y)) begin
      d = bdda_pkg::FIRST_DAY;
      if (m >= bdda_pkg::DECEMBER) begin
        m = bdda_pkg::JANUARY;
        y = y + 1;
      end else begin
        m = m + 1;
      end
    end else begin
      d = d + 1;
    end
  endfunction

  function automatic return_date_t add_business_days(trip_t t);
    int unsigned  y, m, d, used;
    return_date_t r;
    y    = t.year;
    m    = t.month;
    d    = t.day;
    used = 0;
    r    = '0;
    if (y < 1 || y > bdda_pkg::MAX_YEAR || m < bdda_pkg::JANUARY ||
        m > bdda_pkg::DECEMBER || d < bdda_pkg::FIRST_DAY || d > days_in(m, y)) begin
      r.year  = t.year;
      r.month = t.month;
      r.day   = t.day;
      r.bad   = 1'b1;
      return r;
    end
    while (off_day(y, m, d)) advance_day(y, m, d);
    while (used < t.count) begin
      if (!off_day(y, m, d)) used++;
      advance_day(y, m, d);
    end
    while (off_day(y, m, d)) advance_day(y, m, d);
    r.year    = y[bdda_pkg::YEAR_W-1:0];
    r.month   = m[bdda_pkg::MONTH_W-1:0];
    r.day     = d[bdda_pkg::DAY_W-1:0];
    r.weekday = bdda_pkg::WDAY_W'(day_of_week(y, m, d));
    return r;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_returns.push_back(add_business_days(trip_on_bus));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (trips_pending.size() > 0) begin
          trip_on_bus = trips_pending.pop_front();
          in_tdata  <= {{(bdda_pkg::IN_DATA_W - $bits(trip_t)){1'b0}}, trip_on_bus};
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result side: stall pattern ----------------
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    stall_phase++;
    case (stall_mode)
      READY_ALWAYS:   out_tready <= 1'b1;
      READY_RANDOM:   out_tready <= $urandom_range(0, 1);
      default:        out_tready <= (stall_phase % 16) >= 12;
    endcase
  end

  // ---------------- monitor ----------------
  function automatic void check_field(string name, int unsigned exp_val,
                                      int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    return_date_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = return_date_t'({out_tuser, out_tdata[$bits(return_date_t)-2:0]});
      if (due_returns.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        want = due_returns.pop_front();
        check_field("return_year", want.year, got.year);
        check_field("return_month", want.month, got.month);
        check_field("return_day", want.day, got.day);
        check_field("return_weekday", want.weekday, got.weekday);
        check_field("bad_start", want.bad, got.bad);
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_trip(int unsigned y, int unsigned m, int unsigned d,
                          int unsigned n);
    trip_t t;
    t.year  = bdda_pkg::YEAR_W'(y);
    t.month = bdda_pkg::MONTH_W'(m);
    t.day   = bdda_pkg::DAY_W'(d);
    t.count = bdda_pkg::COUNT_W'(n);
    trips_pending.push_back(t);
  endtask

  // hold off until every queued transfer went in and every result came out
  task automatic wait_drained();
    do @(negedge clk);
    while (trips_pending.size() > 0 || in_tvalid || due_returns.size() > 0);
  endtask

  initial begin
    int unsigned pick, y, m, d, n;
    trip_t t;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, weekend starts, leap rules, wraps, bad dates
    add_trip(1, 1, 1, 0);
    add_trip(1, 1, 1, 4095);
    add_trip(9999, 12, 31, 4095);       // largest year reached
    add_trip(9999, 12, 31, 0);
    add_trip(2024, 6, 1, 0);            // Saturday start, zero count
    add_trip(2024, 6, 2, 1);            // Sunday start
    add_trip(2000, 2, 29, 5);           // leap by 400 rule
    add_trip(2024, 2, 29, 3);
    add_trip(1900, 2, 28, 1);           // century, not leap
    add_trip(2023, 12, 29, 2);          // year wrap
    add_trip(2024, 1, 31, 1);
    add_trip(2024, 9, 30, 1);
    add_trip(0, 6, 15, 10);             // year zero
    add_trip(16383, 15, 31, 4095);      // all bits high
    add_trip(10000, 1, 1, 7);
    add_trip(2020, 0, 10, 3);
    add_trip(2020, 13, 10, 3);
    add_trip(2020, 5, 0, 3);
    add_trip(2023, 4, 31, 2);
    add_trip(1900, 2, 29, 2);
    add_trip(2023, 2, 29, 2);
    add_trip(2000, 2, 30, 2);
    wait_drained();

    for (int i = 0; i < RANDOM_TRIPS; i++) begin
      if (i == RANDOM_TRIPS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        case ($urandom_range(0, 7))
          0:       y = 1 + $urandom_range(0, 3);
          1:       y = bdda_pkg::MAX_YEAR - $urandom_range(0, 3);
          2:       y = 400 * $urandom_range(1, 24) + 100 * $urandom_range(0, 3);
          default: y = $urandom_range(1, bdda_pkg::MAX_YEAR);
        endcase
        if (y > bdda_pkg::MAX_YEAR) y = bdda_pkg::MAX_YEAR;
        m = $urandom_range(bdda_pkg::JANUARY, bdda_pkg::DECEMBER);
        d = ($urandom_range(0, 3) == 0) ? days_in(m, y) - $urandom_range(0, 2)
                                         : $urandom_range(1, days_in(m, y));
        pick = $urandom_range(0, 99);
        if (pick < 60)      n = $urandom_range(0, 15);
        else if (pick < 85) n = $urandom_range(16, 511);
        else if (pick < 95) n = $urandom_range(512, 4095);
        else                n = 4095 - $urandom_range(0, 15);
        add_trip(y, m, d, n);
      end else begin
        // unconstrained fields, mostly bad dates; counts kept short
        t       = trip_t'($urandom());
        t.count = t.count & 12'h03F;
        trips_pending.push_back(t);
      end
    end
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
